// File: design/cbps_pkg.sv
// ----------------------------------------------------------------------------
// cbps_pkg
// Types and constants shared by the cell broadcast page scheduler modules.
// ----------------------------------------------------------------------------
package cbps_pkg;

  // Field widths fixed by the item formats
  localparam int unsigned IdxW  = 4;
  localparam int unsigned PageW = 4;
  localparam int unsigned ByteW = 8;
  localparam int unsigned ActW  = 2;

  // Configuration port
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 8;

  localparam logic [CfgIdxW-1:0] REG_BCAST_TRX       = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_BCAST_CHAN_HIGH = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_BCAST_CHAN_LOW  = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_BCAST_ENABLE    = 2'd3;

  // Item opcodes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_RTS  = 1'b1;

  // Result actions
  localparam logic [ActW-1:0] ACT_NONE = 2'd0;
  localparam logic [ActW-1:0] ACT_PAGE = 2'd1;
  localparam logic [ActW-1:0] ACT_NIL  = 2'd2;

  // Input item
  typedef struct packed {
    logic             op;
    logic [IdxW-1:0]  entry_index;
    logic             entry_active;
    logic [PageW-1:0] entry_pages;
    logic [ByteW-1:0] req_trx;
    logic [ByteW-1:0] req_chan_high;
    logic [ByteW-1:0] req_chan_low;
  } cbps_in_t;

  // Result item
  typedef struct packed {
    logic [ActW-1:0]  action;
    logic [IdxW-1:0]  sent_entry;
    logic [PageW-1:0] sent_page;
  } cbps_out_t;

  // One row of the message table
  typedef struct packed {
    logic             active;
    logic [PageW-1:0] total;
    logic [PageW-1:0] count;
  } cbps_entry_t;

  // Value of a row that was never written
  localparam cbps_entry_t ENTRY_RST = '{active: 1'b0, total: '0, count: PageW'(1)};

  // Controller to datapath
  typedef struct packed {
    logic capture;    // latch the accepted item
    logic decode;     // handle load / clear result
    logic walk_start; // remember walk start entry
    logic eval;       // evaluate read row, write back, step pointer
  } cbps_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_hit;     // request addressed to the enabled broadcast channel
    logic eval_done;  // walk finished this cycle (page or nil)
  } cbps_stat_t;

endpackage

// File: design/cbps_ram.sv
// ----------------------------------------------------------------------------
// cbps_ram
// Generic single-port RAM, one write or read per cycle, registered read data.
// ----------------------------------------------------------------------------
module cbps_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/cbps_ctrl.sv
// ----------------------------------------------------------------------------
// cbps_ctrl
// Sequencer: accept an item, decode it, walk the table entry by entry
// (read, then evaluate), and hold the result until it is taken.
// ----------------------------------------------------------------------------
module cbps_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  input  cbps_pkg::cbps_stat_t stat_i,
  output cbps_pkg::cbps_cmd_t  cmd_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_READ   = 3'd2;
  localparam logic [2:0] S_EVAL   = 3'd3;
  localparam logic [2:0] S_OUT    = 3'd4;

  logic [2:0] state_q, state_d;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd_o.decode = 1'b1;
        if (stat_i.is_hit) begin
          cmd_o.walk_start = 1'b1;
          state_d          = S_READ;
        end else begin
          state_d = S_OUT;
        end
      end
      S_READ: begin
        // table read at the walk pointer is issued here; its registered data is used in S_EVAL
        state_d = S_EVAL;
      end
      S_EVAL: begin
        cmd_o.eval = 1'b1;
        state_d    = stat_i.eval_done ? S_OUT : S_READ;
      end
      S_OUT: begin
        if (!out_stall_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = (state_q == S_OUT);

endmodule

// File: design/cbps_dp.sv
// ----------------------------------------------------------------------------
// cbps_dp
// Datapath: configuration registers, message table with per-row valid bits,
// walk pointer and result register.
// ----------------------------------------------------------------------------
module cbps_dp #(
  parameter int unsigned TABLE_ROWS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [cbps_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  logic [cbps_pkg::CfgDataW-1:0]        cfg_wdata_i,
  input  cbps_pkg::cbps_in_t                   in_data_i,
  input  cbps_pkg::cbps_cmd_t                  cmd_i,
  output cbps_pkg::cbps_stat_t                 stat_o,
  output cbps_pkg::cbps_out_t                  out_data_o
);

  localparam int unsigned AW   = $clog2(TABLE_ROWS);
  localparam int unsigned XW   = AW + cbps_pkg::IdxW;
  localparam int unsigned EW   = $bits(cbps_pkg::cbps_entry_t);
  localparam logic [AW-1:0] LAST = AW'(TABLE_ROWS - 1);

  // Configuration registers
  logic [cbps_pkg::ByteW-1:0] bcast_trx_q, bcast_chan_high_q, bcast_chan_low_q;
  logic                       bcast_enable_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bcast_trx_q       <= '0;
      bcast_chan_high_q <= '0;
      bcast_chan_low_q  <= '0;
      bcast_enable_q    <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        cbps_pkg::REG_BCAST_TRX:       bcast_trx_q       <= cfg_wdata_i;
        cbps_pkg::REG_BCAST_CHAN_HIGH: bcast_chan_high_q <= cfg_wdata_i;
        cbps_pkg::REG_BCAST_CHAN_LOW:  bcast_chan_low_q  <= cfg_wdata_i;
        cbps_pkg::REG_BCAST_ENABLE:    bcast_enable_q    <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Captured item
  cbps_pkg::cbps_in_t in_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      in_q <= in_data_i;
    end
  end

  // Decode of the captured item
  logic [XW-1:0] idx_ext;
  logic          load_ok;
  logic [AW-1:0] load_addr;

  assign idx_ext   = XW'(in_q.entry_index);
  assign load_ok   = (in_q.op == cbps_pkg::OP_LOAD) && (idx_ext < XW'(TABLE_ROWS));
  assign load_addr = idx_ext[AW-1:0];

  assign stat_o.is_hit = (in_q.op == cbps_pkg::OP_RTS) && bcast_enable_q &&
                         (in_q.req_trx == bcast_trx_q) &&
                         (in_q.req_chan_high == bcast_chan_high_q) &&
                         (in_q.req_chan_low == bcast_chan_low_q);

  // Walk pointer and start entry
  logic [AW-1:0] ptr_q, ptr_d, start_q, nxt;

  assign nxt = (ptr_q == LAST) ? '0 : ptr_q + AW'(1);

  // Table read data; rows never written read as the reset row
  logic [TABLE_ROWS-1:0]   valid_q, valid_d;
  logic [EW-1:0]           rdata;
  cbps_pkg::cbps_entry_t   ent, wr_ent;
  logic                    advance, send, wr_eval, nil;

  assign ent = valid_q[ptr_q] ? cbps_pkg::cbps_entry_t'(rdata) : cbps_pkg::ENTRY_RST;

  // Row evaluation
  always_comb begin
    advance = 1'b0;
    send    = 1'b0;
    wr_eval = 1'b0;
    wr_ent  = ent;
    if (!ent.active) begin
      advance = 1'b1;
    end else if (ent.total == '0) begin
      wr_ent.active = 1'b0;
      wr_eval       = 1'b1;
      advance       = 1'b1;
    end else if (ent.count < ent.total) begin
      send         = 1'b1;
      wr_eval      = 1'b1;
      wr_ent.count = ent.count + cbps_pkg::PageW'(1);
    end else begin
      send         = 1'b1;
      wr_eval      = 1'b1;
      wr_ent.count = cbps_pkg::PageW'(1);
      advance      = 1'b1;
    end
  end

  assign nil = !send && (nxt == start_q);
  assign stat_o.eval_done = send || nil;

  // Table port: load write, walk read or walk write-back
  logic                  ram_we;
  logic [AW-1:0]         ram_addr;
  cbps_pkg::cbps_entry_t ram_wdata;

  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = ptr_q;
    ram_wdata = wr_ent;
    if (cmd_i.decode) begin
      ram_addr  = load_addr;
      ram_we    = load_ok;
      ram_wdata = '{active: in_q.entry_active, total: in_q.entry_pages,
                    count: cbps_pkg::PageW'(1)};
    end else if (cmd_i.eval) begin
      ram_we = wr_eval;
    end
  end

  cbps_ram #(
    .WIDTH (EW),
    .DEPTH (TABLE_ROWS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (rdata)
  );

  // Valid bits and walk pointer
  always_comb begin
    valid_d = valid_q;
    if (ram_we) begin
      valid_d[ram_addr] = 1'b1;
    end
    ptr_d = ptr_q;
    if (cmd_i.eval && advance) begin
      ptr_d = nxt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      ptr_q   <= '0;
    end else begin
      valid_q <= valid_d;
      ptr_q   <= ptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.walk_start) begin
      start_q <= ptr_q;
    end
  end

  // Result register
  cbps_pkg::cbps_out_t res_q;
  logic [XW-1:0]       ptr_ext;

  assign ptr_ext = XW'(ptr_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.decode) begin
      res_q <= '0;
    end else if (cmd_i.eval) begin
      if (send) begin
        res_q.action     <= cbps_pkg::ACT_PAGE;
        res_q.sent_entry <= ptr_ext[cbps_pkg::IdxW-1:0];
        res_q.sent_page  <= ent.count;
      end else if (nil) begin
        res_q.action <= cbps_pkg::ACT_NIL;
      end
    end
  end

  assign out_data_o = res_q;

endmodule

// File: design/cell_broadcast_page_scheduler.sv
// ----------------------------------------------------------------------------
// cell_broadcast_page_scheduler
// Round-robin page scheduler over a table of cell broadcast messages.
// ----------------------------------------------------------------------------
// One item is handled at a time. A load, or a request that is not for the
// enabled broadcast channel, goes through the accept, decode and output
// states, and its result is held in the output state until it is taken. A
// ready-to-send walk visits k (1 to TABLE_ROWS) table entries between decode
// and output: the table sits in a single-port memory with registered read, so
// each entry takes a read state followed by an evaluate/write-back state.
// Rows never loaded since reset read as inactive through per-row valid bits,
// so no clearing pass is needed.
module cell_broadcast_page_scheduler #(
  parameter int unsigned TABLE_ROWS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [cbps_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [cbps_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  cbps_pkg::cbps_in_t            in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output cbps_pkg::cbps_out_t           out_data_o
);

  cbps_pkg::cbps_cmd_t  cmd;
  cbps_pkg::cbps_stat_t stat;

  // Sequencer
  cbps_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Table, registers and result
  cbps_dp #(
    .TABLE_ROWS (TABLE_ROWS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_data_o  (out_data_o)
  );

endmodule
